@@ hdl/cdq_pkg.sv @@
// Shared types and constants for the circular deque.
package cdq_pkg;

   // Default number of entries in the circular store
   localparam int DEPTH_DEF = 16;

   // Field widths of the request and response
   localparam int CMD_W       = 3;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4
   } cmd_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Source of the response word
   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_READ,
      OUT_ONES
   } out_sel_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // apply the captured request to the deque
   } dp_ctl_type;

endpackage

@@ hdl/cdq_ctrl.sv @@
// Controller state machine: request capture, execute, response handshake.
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_ctl_type ctl
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ctl.load   = 1'b0;
      ctl.exec   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_tvalid;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/cdq_dp.sv @@
// Datapath: circular store, head/tail indices, entry count and response fields.
module cdq_dp
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)(
   input  logic                          clock,
   input  logic                          reset,
   input  dp_ctl_type                    ctl,
   input  logic [CMD_W-1:0]              cmd,
   input  logic signed [WORD_W-1:0]      push_value,
   output logic signed [WORD_W-1:0]      out_value,
   output logic [STATUS_W-1:0]           status,
   output logic                          is_empty,
   output logic                          is_full,
   output logic [COUNT_OUT_W-1:0]        entry_count
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // Circular store
   logic [WORD_W-1:0] mem [DEPTH];

   cmd_type                 cmd_ff;
   logic [WORD_W-1:0]       value_ff;
   logic [IW-1:0]           head_ff, head_in;
   logic [IW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   status_type              status_ff, status_in;
   out_sel_type             sel_ff, sel_in;
   logic [WORD_W-1:0]       rd_data_ff;
   logic [IW-1:0]           rd_addr;
   logic [IW-1:0]           wr_addr;
   logic                    wr_en;
   logic                    empty_now;
   logic                    full_now;

   function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   // Request capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd_type'(cmd);
         value_ff <= push_value;
      end
   end

   assign empty_now = (count_ff == '0);
   assign full_now  = (count_ff == FULL_CNT);

   // Command decode and next state of the deque
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      sel_in    = OUT_ZERO;
      rd_addr   = head_ff;
      wr_addr   = tail_ff;
      wr_en     = 1'b0;
      case (cmd_ff)
         CMD_PUSH_BACK: begin
            if (full_now) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               tail_in  = idx_next(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (full_now) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_prev(head_ff);
               head_in  = idx_prev(head_ff);
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty_now) begin
               status_in = STAT_EMPTY;
               sel_in    = OUT_ONES;
            end else begin
               sel_in   = OUT_READ;
               rd_addr  = head_ff;
               head_in  = idx_next(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty_now) begin
               status_in = STAT_EMPTY;
               sel_in    = OUT_ONES;
            end else begin
               sel_in   = OUT_READ;
               rd_addr  = idx_prev(tail_ff);
               tail_in  = idx_prev(tail_ff);
               count_in = count_ff - 1'b1;
            end
         end
         CMD_PEEK_FRONT: begin
            if (empty_now) begin
               status_in = STAT_EMPTY;
               sel_in    = OUT_ONES;
            end else begin
               sel_in  = OUT_READ;
               rd_addr = head_ff;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // Indices, count and response status
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         status_ff <= STAT_OK;
         sel_ff    <= OUT_ZERO;
      end else if (ctl.exec) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         sel_ff    <= sel_in;
      end
   end

   // Store: one write port, one registered read port held while the response waits
   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (ctl.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Response fields
   always_comb begin
      case (sel_ff)
         OUT_READ: out_value = rd_data_ff;
         OUT_ONES: out_value = '1;
         default:  out_value = '0;
      endcase
   end

   assign status      = status_ff;
   assign is_empty    = empty_now;
   assign is_full     = full_now;
   assign entry_count = COUNT_OUT_W'(count_ff);

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !ctl.exec |=> count_ff == $past(count_ff))
      else $error("entry count moved outside execute");

   a_idx_meet: assert property (@(posedge clock) disable iff (reset)
      (empty_now || full_now) |-> head_ff == tail_ff)
      else $error("head and tail disagree with count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      status_ff == STAT_EMPTY |-> empty_now)
      else $error("empty status with entries held");

endmodule

@@ hdl/circular_deque.sv @@
// Top level of the circular deque: controller plus datapath.
// A request is accepted in S_IDLE, applied to the deque in S_EXEC, and its
// response is held valid in S_RESP until rsp_tready takes it.
// No new request is accepted until that response has been taken; the
// registered read of the circular store happens in S_EXEC.
// Reset clears head, tail and entry count; store contents stay undefined and
// are only read after a push has written them.
module circular_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cmd [2:0], push_value [34:3], unused [39:35]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_value [31:0], status [33:32], is_empty [34], is_full [35],
   // entry_count [40:36], zero fill [47:41]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   dp_ctl_type               ctl;
   logic signed [WORD_W-1:0] out_value;
   logic [STATUS_W-1:0]      status;
   logic                     is_empty;
   logic                     is_full;
   logic [COUNT_OUT_W-1:0]   entry_count;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cmd         (req_tdata[2:0]),
      .push_value  (req_tdata[34:3]),
      .out_value   (out_value),
      .status      (status),
      .is_empty    (is_empty),
      .is_full     (is_full),
      .entry_count (entry_count)
   );

   // Response packing
   assign rsp_tdata = {7'd0, entry_count, is_full, is_empty, status, out_value};

endmodule
